// ----- rtl/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared sizes, request codes and character constants of the text console
// writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLS  = 80;
	localparam int ROWS  = 25;
	localparam int CELLS = COLS * ROWS;

	// memory address, cursor (0..CELLS) and column widths
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CUR_W  = $clog2(CELLS + 1);
	localparam int COL_W  = $clog2(COLS);

	// fixed field widths
	localparam int REQ_W  = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 11;

	localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

	// configuration register byte address
	localparam logic [1:0] TEXT_COLOR_ADDR = 2'd0;

	localparam logic [7:0] COLOR_RESET = 8'd15;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CHAR_W-1:0] char_t;

endpackage

// ----- rtl/text_console_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Character store with cursor: put, clear and read requests, scroll on
// overflow, APB register for the text attribute.
// ----------------------------------------------------------------------------
// A put without scroll strobes done in the cycle after the transfer and
//   leaves busy low, so puts run at one per cycle; a read goes through ST_READ.
// A clear walks the store through its single write port, one cell at a time.
// A put at the past-end cursor scrolls first: one copy per cycle through the
//   store, then the character is written at the start of the last row.
// Reset: a clearing pass fills the store with spaces with busy high;
//   results cannot be stalled, done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module text_console_writer
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              start,
	output logic              busy,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [IDX_W-1:0]  cell_index,
	// result channel
	output logic              done,
	output logic [CHAR_W-1:0] cell_char,
	output logic [POS_W-1:0]  cursor_pos,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [1:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CLEAR  = 3'd1;
	localparam logic [2:0] ST_SCROLL = 3'd2;
	localparam logic [2:0] ST_PUT    = 3'd3;
	localparam logic [2:0] ST_READ   = 3'd4;

	localparam logic [CUR_W-1:0] CUR_CELLS    = CUR_W'(CELLS);
	localparam logic [CUR_W-1:0] CUR_LASTROW  = CUR_W'(CELLS - COLS);
	localparam logic [CUR_W-1:0] CUR_COLS     = CUR_W'(COLS);
	localparam logic [COL_W-1:0] COL_LAST     = COL_W'(COLS - 1);
	localparam addr_t            ADDR_LAST    = ADDR_W'(CELLS - 1);
	localparam addr_t            ADDR_LASTROW = ADDR_W'(CELLS - COLS);

	logic [2:0]        state_q;
	logic [CUR_W-1:0]  cnt_q;
	logic              report_q;
	logic [CUR_W-1:0]  row_base_q;
	logic [COL_W-1:0]  col_q;
	char_t             ch_q;
	logic              rd_ok_q;
	logic [7:0]        text_color_q;

	logic              done_q;
	char_t             cell_char_q;
	logic [POS_W-1:0]  cursor_pos_q;

	// scroll write stage
	logic              wr_v_s1;
	addr_t             wr_addr_s1;
	logic              keep_s1;

	logic              mem_we;
	addr_t             mem_waddr;
	char_t             mem_wdata;
	addr_t             mem_raddr;
	char_t             mem_rdata;

	logic [CUR_W-1:0]  cursor;
	logic              at_end;
	logic              accept;
	logic [CUR_W-1:0]  adv_base;
	logic [COL_W-1:0]  adv_col;
	logic [CUR_W-1:0]  src_base;
	logic [COL_W-1:0]  src_col;
	char_t             src_char;

	assign cursor = row_base_q + CUR_W'(col_q);
	assign at_end = (row_base_q == CUR_CELLS);
	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// cursor step for one put: from the live cursor, or from the last row
	// start once a scroll has finished
	always_comb begin
		if (state_q == ST_PUT) begin
			src_base = CUR_LASTROW;
			src_col  = '0;
			src_char = ch_q;
		end else begin
			src_base = row_base_q;
			src_col  = col_q;
			src_char = char_code;
		end
		if (src_char == NEWLINE_CHAR || src_col == COL_LAST) begin
			adv_base = src_base + CUR_COLS;
			adv_col  = '0;
		end else begin
			adv_base = src_base;
			adv_col  = src_col + COL_W'(1);
		end
	end

	// store port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = SPACE_CHAR;
		mem_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				mem_we    = accept && (req_type == REQ_PUT) && !at_end
					&& (char_code != NEWLINE_CHAR);
				mem_waddr = ADDR_W'(cursor);
				mem_wdata = char_code;
				if (cell_index < IDX_W'(CELLS)) begin
					mem_raddr = ADDR_W'(cell_index);
				end
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(cnt_q);
			end
			ST_SCROLL: begin
				mem_we    = wr_v_s1;
				mem_waddr = wr_addr_s1;
				mem_wdata = keep_s1 ? mem_rdata : SPACE_CHAR;
				if (cnt_q < CUR_LASTROW) begin
					mem_raddr = ADDR_W'(cnt_q + CUR_COLS);
				end
			end
			ST_PUT: begin
				mem_we    = (ch_q != NEWLINE_CHAR);
				mem_waddr = ADDR_LASTROW;
				mem_wdata = ch_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	tcw_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cnt_q      <= '0;
			report_q   <= 1'b0;
			row_base_q <= '0;
			col_q      <= '0;
			done_q     <= 1'b0;
			wr_v_s1    <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			wr_v_s1 <= (state_q == ST_SCROLL) && (cnt_q < CUR_CELLS);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_PUT: begin
								if (at_end) begin
									state_q <= ST_SCROLL;
									cnt_q   <= '0;
								end else begin
									row_base_q   <= adv_base;
									col_q        <= adv_col;
									done_q       <= 1'b1;
									cell_char_q  <= '0;
									cursor_pos_q <= POS_W'(adv_base + CUR_W'(adv_col));
								end
							end
							REQ_CLEAR: begin
								state_q    <= ST_CLEAR;
								cnt_q      <= '0;
								report_q   <= 1'b1;
								row_base_q <= '0;
								col_q      <= '0;
							end
							REQ_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								done_q       <= 1'b1;
								cell_char_q  <= '0;
								cursor_pos_q <= POS_W'(cursor);
							end
						endcase
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + CUR_W'(1);
					if (cnt_q == CUR_W'(CELLS - 1)) begin
						state_q      <= ST_IDLE;
						done_q       <= report_q;
						report_q     <= 1'b0;
						cell_char_q  <= '0;
						cursor_pos_q <= '0;
					end
				end
				ST_SCROLL: begin
					if (cnt_q < CUR_CELLS) begin
						cnt_q <= cnt_q + CUR_W'(1);
					end
					// leave once the last row's final space is written
					if (wr_v_s1 && wr_addr_s1 == ADDR_LAST) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					state_q      <= ST_IDLE;
					row_base_q   <= adv_base;
					col_q        <= adv_col;
					done_q       <= 1'b1;
					cell_char_q  <= '0;
					cursor_pos_q <= POS_W'(adv_base + CUR_W'(adv_col));
				end
				ST_READ: begin
					state_q      <= ST_IDLE;
					done_q       <= 1'b1;
					cell_char_q  <= rd_ok_q ? mem_rdata : '0;
					cursor_pos_q <= POS_W'(cursor);
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q    <= char_code;
			rd_ok_q <= (cell_index < IDX_W'(CELLS));
		end
		wr_addr_s1 <= ADDR_W'(cnt_q);
		keep_s1    <= (cnt_q < CUR_LASTROW);
	end

	// configuration register
	assign pready = 1'b1;
	assign prdata = {24'd0, text_color_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= COLOR_RESET;
		end else if (psel && penable && pwrite && pready && paddr == TEXT_COLOR_ADDR) begin
			text_color_q <= pwdata[7:0];
		end
	end

	assign done       = done_q;
	assign cell_char  = cell_char_q;
	assign cursor_pos = cursor_pos_q;

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor <= CUR_CELLS)
		else $error("cursor beyond past-end position");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_LAST && (!at_end || col_q == '0))
		else $error("column out of range");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_CLEAR) |=> busy && cursor == '0)
		else $error("clear transfer did not start the clearing pass");

	a_cursor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !(accept && (req_type == REQ_PUT || req_type == REQ_CLEAR)))
		|=> $stable(cursor))
		else $error("cursor moved without a put or clear");

	a_scroll_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL && wr_v_s1) |-> wr_addr_s1 <= ADDR_LAST)
		else $error("scroll write outside the store");

endmodule

// ----- rtl/tcw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Character store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram
	import tcw_pkg::*;
(
	input  logic  clk,
	input  logic  we,
	input  addr_t waddr,
	input  char_t wdata,
	input  addr_t raddr,
	output char_t rdata
);

	char_t mem [CELLS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
